FILE: sv/sal_pkg.sv
// shared types and constants for the sorted array list core
// no dependencies
package sal_pkg;

  localparam int DEPTH = 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 8;
  localparam int IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_SHOW   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

endpackage

FILE: sv/sorted_array_list_core.sv
// sorted list of signed bytes in one synchronous ram with a read/check sequencer; uses sal_pkg
// full or empty is reported straight from idle; otherwise the sequencer alternates a ram read
// and a check per visited entry: insert walks down from the top, moving larger entries up,
// delete and a search miss visit every entry, a search hit stops at the match, and show gives
// one result per entry with last set on the final one; busy stays high until the final result
// reset clears the count and control state, not the ram; the receiver cannot stall results
module sorted_array_list_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command,
  input  logic signed [sal_pkg::DATA_W-1:0] value,
  output logic                              strobe,
  output logic [1:0]                        status,
  output logic [sal_pkg::IDX_W-1:0]         index,
  output logic signed [sal_pkg::DATA_W-1:0] entry_value,
  output logic                              last
);

  logic signed [sal_pkg::DATA_W-1:0] mem [sal_pkg::DEPTH];
  logic signed [sal_pkg::DATA_W-1:0] rd_data;
  logic [sal_pkg::ADDR_W-1:0]        rd_addr;
  logic                              we;
  logic [sal_pkg::ADDR_W-1:0]        wa;
  logic signed [sal_pkg::DATA_W-1:0] wd;

  sal_pkg::state_t                   state, state_next;
  sal_pkg::cmd_t                     cmd, cmd_next;
  logic signed [sal_pkg::DATA_W-1:0] operand, operand_next;
  logic [sal_pkg::CNT_W-1:0]         ptr, ptr_next;
  logic [sal_pkg::CNT_W-1:0]         count, count_next;
  logic                              found, found_next;
  logic                              strobe_next;
  sal_pkg::status_t                  status_next;
  logic [sal_pkg::IDX_W-1:0]         index_next;
  logic signed [sal_pkg::DATA_W-1:0] entry_value_next;
  logic                              last_next;
  logic [sal_pkg::CNT_W-1:0]         ptr_dec, ptr_inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  assign ptr_dec = ptr - 1'b1;
  assign ptr_inc = ptr + 1'b1;
  assign busy = (state != sal_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sal_pkg::S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
    cmd         <= cmd_next;
    operand     <= operand_next;
    ptr         <= ptr_next;
    found       <= found_next;
    status      <= status_next;
    index       <= index_next;
    entry_value <= entry_value_next;
    last        <= last_next;
  end

  always_comb begin
    state_next       = state;
    cmd_next         = cmd;
    operand_next     = operand;
    ptr_next         = ptr;
    count_next       = count;
    found_next       = found;
    strobe_next      = 1'b0;
    status_next      = sal_pkg::ST_OK;
    index_next       = '0;
    entry_value_next = '0;
    last_next        = 1'b1;
    rd_addr          = ptr[sal_pkg::ADDR_W-1:0];
    we               = 1'b0;
    wa               = ptr[sal_pkg::ADDR_W-1:0];
    wd               = operand;

    unique case (state)
      sal_pkg::S_IDLE: begin
        if (start) begin
          cmd_next     = sal_pkg::cmd_t'(command);
          operand_next = value;
          found_next   = 1'b0;
          if (sal_pkg::cmd_t'(command) == sal_pkg::CMD_INSERT) begin
            if (count == sal_pkg::CNT_W'(sal_pkg::DEPTH)) begin
              strobe_next = 1'b1;
              status_next = sal_pkg::ST_FULL;
            end else begin
              ptr_next   = count;
              state_next = sal_pkg::S_READ;
            end
          end else if (count == '0) begin
            strobe_next = 1'b1;
            status_next = sal_pkg::ST_EMPTY;
          end else begin
            ptr_next   = '0;
            state_next = sal_pkg::S_READ;
          end
        end
      end

      sal_pkg::S_READ: begin
        unique case (cmd)
          sal_pkg::CMD_INSERT: begin
            if (ptr == '0) begin
              we          = 1'b1;
              wa          = '0;
              wd          = operand;
              count_next  = count + 1'b1;
              strobe_next = 1'b1;
              state_next  = sal_pkg::S_IDLE;
            end else begin
              rd_addr    = ptr_dec[sal_pkg::ADDR_W-1:0];
              state_next = sal_pkg::S_CHECK;
            end
          end
          sal_pkg::CMD_DELETE: begin
            if (ptr == count) begin
              strobe_next = 1'b1;
              state_next  = sal_pkg::S_IDLE;
              if (found) begin
                count_next = count - 1'b1;
              end else begin
                status_next = sal_pkg::ST_MISS;
              end
            end else begin
              state_next = sal_pkg::S_CHECK;
            end
          end
          sal_pkg::CMD_SEARCH: begin
            if (ptr == count) begin
              strobe_next = 1'b1;
              status_next = sal_pkg::ST_MISS;
              state_next  = sal_pkg::S_IDLE;
            end else begin
              state_next = sal_pkg::S_CHECK;
            end
          end
          default: begin
            state_next = sal_pkg::S_CHECK;
          end
        endcase
      end

      sal_pkg::S_CHECK: begin
        unique case (cmd)
          sal_pkg::CMD_INSERT: begin
            we = 1'b1;
            wa = ptr[sal_pkg::ADDR_W-1:0];
            if (rd_data > operand) begin
              wd         = rd_data;
              ptr_next   = ptr_dec;
              state_next = sal_pkg::S_READ;
            end else begin
              wd          = operand;
              count_next  = count + 1'b1;
              strobe_next = 1'b1;
              state_next  = sal_pkg::S_IDLE;
            end
          end
          sal_pkg::CMD_DELETE: begin
            if (found) begin
              we = 1'b1;
              wa = ptr_dec[sal_pkg::ADDR_W-1:0];
              wd = rd_data;
            end else if (rd_data == operand) begin
              found_next = 1'b1;
            end
            ptr_next   = ptr_inc;
            state_next = sal_pkg::S_READ;
          end
          sal_pkg::CMD_SEARCH: begin
            if (rd_data == operand) begin
              strobe_next = 1'b1;
              index_next  = sal_pkg::IDX_W'(ptr);
              state_next  = sal_pkg::S_IDLE;
            end else begin
              ptr_next   = ptr_inc;
              state_next = sal_pkg::S_READ;
            end
          end
          default: begin
            strobe_next      = 1'b1;
            index_next       = sal_pkg::IDX_W'(ptr);
            entry_value_next = rd_data;
            last_next        = (ptr_inc == count);
            ptr_next         = ptr_inc;
            state_next       = (ptr_inc == count) ? sal_pkg::S_IDLE : sal_pkg::S_READ;
          end
        endcase
      end

      default: begin
        state_next = sal_pkg::S_IDLE;
      end
    endcase
  end

endmodule
